### design/lfu_pkg.sv
// lfu_pkg: shared sizes and the command/status structs between controller and datapath
// of the lfu page cache directory. No dependencies.
package lfu_pkg;

	localparam int SLOTS      = 16;
	localparam int COUNT_BITS = 16;
	localparam int PAGE_W     = 32;
	localparam int IDX_W      = 4;   // width of the slot fields
	localparam int NSLOT_W    = 5;   // width of the active_slots register

	// controller -> datapath
	typedef struct packed {
		logic             load;        // latch a new request, clear scan trackers
		logic             track;       // fold slot idx into free / victim search
		logic             hit_upd;     // hit at idx: bump count, emit hit beat
		logic             alloc;       // miss end: fill target slot, emit beat
		logic             flush_take;  // flush dirty slot idx
		logic             flush_end;   // emit final flush beat
		logic [IDX_W-1:0] idx;
	} lfu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic match;       // slot idx holds the requested page
		logic dirty_live;  // slot idx is valid and dirty
		logic pend;        // a flush beat is held back
		logic out_free;    // output register can take a beat this cycle
	} lfu_sts_t;

endpackage

### design/lfu_req_if.sv
// lfu_req_if: request channel of the directory (valid/ready plus access fields).
// Depends on nothing.
interface lfu_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] page_number;
	logic        is_write;

	modport source (output valid, func, page_number, is_write, input ready);
	modport sink   (input valid, func, page_number, is_write, output ready);
endinterface

### design/lfu_res_if.sv
// lfu_res_if: result channel of the directory (valid/ready plus result fields).
// Depends on nothing.
interface lfu_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  slot;
	logic        hit;
	logic        fill_needed;
	logic        writeback_valid;
	logic [3:0]  writeback_slot;
	logic [31:0] writeback_page;
	logic        last;

	modport source (output valid, slot, hit, fill_needed, writeback_valid, writeback_slot,
		writeback_page, last, input ready);
	modport sink   (input valid, slot, hit, fill_needed, writeback_valid, writeback_slot,
		writeback_page, last, output ready);
endinterface

### design/lfu_cfg_if.sv
// lfu_cfg_if: configuration write channel carrying the active_slots register.
// Depends on nothing.
interface lfu_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] active_slots;

	modport source (output valid, active_slots, input ready);
	modport sink   (input valid, active_slots, output ready);
endinterface

### design/lfu_page_cache_directory.sv
// lfu_page_cache_directory: top level of the lfu page cache directory.
// Depends on lfu_pkg, lfu_req_if, lfu_res_if, lfu_cfg_if, lfu_ctrl, lfu_dp.
//
// Directory of a fully associative page cache with least-frequently-used
// replacement. One request is worked on at a time; the scan looks at one slot
// per clock, but it waits at a hit or a dirty flush slot while a beat cannot
// go out. With n active slots (active_slots clamped to 1..16), a miss walks all
// n slots, a hit stops at its slot and a flush walks all n, and any stall on
// the result side adds to the cost. A flush delivers one beat per dirty live
// slot in slot order (or one all-zero beat with last set when nothing is dirty);
// the last beat of every request has last set. The output register lets the
// next request be accepted while the previous result beat still waits.
// active_slots may be written only while the block is idle.
module lfu_page_cache_directory (
	input  logic     clk,
	input  logic     arst_n,
	lfu_cfg_if.sink  cfg,
	lfu_req_if.sink  req,
	lfu_res_if.source res
);
	import lfu_pkg::*;

	lfu_cmd_t cmd;
	lfu_sts_t sts;
	logic     ctl_ready;

	// config writes are always taken
	assign cfg.ready = 1'b1;
	assign req.ready = ctl_ready;

	// sequencer: idle / access scan / miss fill / flush walk / flush close
	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (ctl_ready),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.active_slots),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage, lfu victim tracking and the result register
	lfu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_page  (req.page_number),
		.req_write (req.is_write),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_slot  (res.slot),
		.out_hit   (res.hit),
		.out_fill  (res.fill_needed),
		.out_wbv   (res.writeback_valid),
		.out_wbs   (res.writeback_slot),
		.out_wbp   (res.writeback_page),
		.out_last  (res.last)
	);

endmodule

### design/lfu_ctrl.sv
// lfu_ctrl: scan sequencer of the directory; owns the active_slots register.
// Depends on lfu_pkg.
module lfu_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_func,
	output logic                          req_ready,
	input  logic                          cfg_valid,
	input  logic [lfu_pkg::NSLOT_W-1:0]   cfg_data,
	input  lfu_pkg::lfu_sts_t             sts,
	output lfu_pkg::lfu_cmd_t             cmd
);
	import lfu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ACC, ST_ACC_END, ST_FLUSH, ST_FLUSH_END
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [NSLOT_W-1:0] active_q;
	logic [NSLOT_W-1:0] n_use;
	logic [IDX_W-1:0]   last_idx;
	logic               at_end;
	logic               step;

	// clamp to 1..SLOTS
	always_comb begin
		if (active_q == '0) begin
			n_use = NSLOT_W'(1);
		end else if (active_q > NSLOT_W'(SLOTS)) begin
			n_use = NSLOT_W'(SLOTS);
		end else begin
			n_use = active_q;
		end
	end
	assign last_idx  = IDX_W'(n_use - NSLOT_W'(1));
	assign at_end    = (idx_q == last_idx);
	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.idx  = idx_q;
		step     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = req_valid;
			end
			ST_ACC: begin
				if (sts.match) begin
					cmd.hit_upd = sts.out_free;
				end else begin
					cmd.track = 1'b1;
					step      = 1'b1;
				end
			end
			ST_ACC_END: begin
				cmd.alloc = sts.out_free;
			end
			ST_FLUSH: begin
				cmd.flush_take = sts.dirty_live && (!sts.pend || sts.out_free);
				step           = !sts.dirty_live || cmd.flush_take;
			end
			ST_FLUSH_END: begin
				cmd.flush_end = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			active_q <= NSLOT_W'(16);
		end else begin
			if (cfg_valid) begin
				active_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						idx_q   <= '0;
						state_q <= req_func ? ST_FLUSH : ST_ACC;
					end
				end
				ST_ACC: begin
					if (cmd.hit_upd) begin
						state_q <= ST_IDLE;
					end else if (step) begin
						if (at_end) begin
							state_q <= ST_ACC_END;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_ACC_END: begin
					if (cmd.alloc) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (step) begin
						if (at_end) begin
							state_q <= ST_FLUSH_END;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_FLUSH_END: begin
					if (cmd.flush_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/lfu_dp.sv
// lfu_dp: directory storage, scan trackers, held flush beat and output register.
// Depends on lfu_pkg.
module lfu_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lfu_pkg::lfu_cmd_t            cmd,
	output lfu_pkg::lfu_sts_t            sts,
	input  logic [lfu_pkg::PAGE_W-1:0]   req_page,
	input  logic                         req_write,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lfu_pkg::IDX_W-1:0]    out_slot,
	output logic                         out_hit,
	output logic                         out_fill,
	output logic                         out_wbv,
	output logic [lfu_pkg::IDX_W-1:0]    out_wbs,
	output logic [lfu_pkg::PAGE_W-1:0]   out_wbp,
	output logic                         out_last
);
	import lfu_pkg::*;

	logic [SLOTS-1:0]      valid_q;
	logic [SLOTS-1:0]      dirty_q;
	logic [PAGE_W-1:0]     page_q [SLOTS];
	logic [COUNT_BITS-1:0] cnt_q  [SLOTS];

	logic [PAGE_W-1:0]     rq_page_q;
	logic                  rq_wr_q;

	logic                  have_free_q;
	logic [IDX_W-1:0]      free_q;
	logic                  have_vic_q;
	logic [IDX_W-1:0]      vic_q;
	logic [COUNT_BITS-1:0] min_q;
	logic [PAGE_W-1:0]     vic_page_q;

	logic                  pend_q;
	logic [IDX_W-1:0]      pend_slot_q;
	logic [PAGE_W-1:0]     pend_page_q;

	logic                  o_valid_q;
	logic [IDX_W-1:0]      o_slot_q;
	logic                  o_hit_q;
	logic                  o_fill_q;
	logic                  o_wbv_q;
	logic [IDX_W-1:0]      o_wbs_q;
	logic [PAGE_W-1:0]     o_wbp_q;
	logic                  o_last_q;

	logic [PAGE_W-1:0]     cur_page;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic                  cur_valid;
	logic                  out_free;
	logic [IDX_W-1:0]      tgt;
	logic                  emit;
	logic                  take_vic;

	assign cur_page  = page_q[cmd.idx];
	assign cur_cnt   = cnt_q[cmd.idx];
	assign cur_valid = valid_q[cmd.idx];
	assign out_free  = !o_valid_q || out_ready;
	assign tgt       = have_free_q ? free_q : vic_q;
	assign take_vic  = cur_valid && (!have_vic_q || cur_cnt < min_q);
	assign emit      = cmd.hit_upd || cmd.alloc || cmd.flush_end ||
		(cmd.flush_take && pend_q);

	assign sts.match      = cur_valid && (cur_page == rq_page_q);
	assign sts.dirty_live = cur_valid && dirty_q[cmd.idx];
	assign sts.pend       = pend_q;
	assign sts.out_free   = out_free;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			dirty_q     <= '0;
			have_free_q <= 1'b0;
			have_vic_q  <= 1'b0;
			pend_q      <= 1'b0;
			o_valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				have_free_q <= 1'b0;
				have_vic_q  <= 1'b0;
				pend_q      <= 1'b0;
			end
			if (cmd.track) begin
				if (!cur_valid) begin
					have_free_q <= 1'b1;
				end
				if (take_vic) begin
					have_vic_q <= 1'b1;
				end
			end
			if (cmd.hit_upd && rq_wr_q) begin
				dirty_q[cmd.idx] <= 1'b1;
			end
			if (cmd.alloc) begin
				valid_q[tgt] <= 1'b1;
				dirty_q[tgt] <= rq_wr_q;
			end
			if (cmd.flush_take) begin
				valid_q[cmd.idx] <= 1'b0;
				dirty_q[cmd.idx] <= 1'b0;
				pend_q           <= 1'b1;
			end
			if (cmd.flush_end) begin
				pend_q <= 1'b0;
			end
			if (emit) begin
				o_valid_q <= 1'b1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rq_page_q <= req_page;
			rq_wr_q   <= req_write;
		end
		if (cmd.track) begin
			if (!cur_valid && !have_free_q) begin
				free_q <= cmd.idx;
			end
			if (take_vic) begin
				vic_q      <= cmd.idx;
				min_q      <= cur_cnt;
				vic_page_q <= cur_page;
			end
		end
		if (cmd.hit_upd && cur_cnt != '1) begin
			cnt_q[cmd.idx] <= cur_cnt + COUNT_BITS'(1);
		end
		if (cmd.alloc) begin
			page_q[tgt] <= rq_page_q;
			cnt_q[tgt]  <= COUNT_BITS'(1);
		end
		if (cmd.flush_take) begin
			pend_slot_q <= cmd.idx;
			pend_page_q <= cur_page;
		end
		if (emit) begin
			if (cmd.hit_upd) begin
				o_slot_q <= cmd.idx;
				o_hit_q  <= 1'b1;
				o_fill_q <= 1'b0;
				o_wbv_q  <= 1'b0;
				o_wbs_q  <= '0;
				o_wbp_q  <= '0;
				o_last_q <= 1'b1;
			end else if (cmd.alloc) begin
				// eviction only when no free slot was seen
				o_slot_q <= tgt;
				o_hit_q  <= 1'b0;
				o_fill_q <= !rq_wr_q;
				o_wbv_q  <= !have_free_q;
				o_wbs_q  <= have_free_q ? '0 : vic_q;
				o_wbp_q  <= have_free_q ? '0 : vic_page_q;
				o_last_q <= 1'b1;
			end else if (pend_q) begin
				// held flush beat; last only when the scan is over
				o_slot_q <= pend_slot_q;
				o_hit_q  <= 1'b0;
				o_fill_q <= 1'b0;
				o_wbv_q  <= 1'b1;
				o_wbs_q  <= pend_slot_q;
				o_wbp_q  <= pend_page_q;
				o_last_q <= cmd.flush_end;
			end else begin
				// flush with nothing dirty
				o_slot_q <= '0;
				o_hit_q  <= 1'b0;
				o_fill_q <= 1'b0;
				o_wbv_q  <= 1'b0;
				o_wbs_q  <= '0;
				o_wbp_q  <= '0;
				o_last_q <= 1'b1;
			end
		end
	end

	assign out_valid = o_valid_q;
	assign out_slot  = o_slot_q;
	assign out_hit   = o_hit_q;
	assign out_fill  = o_fill_q;
	assign out_wbv   = o_wbv_q;
	assign out_wbs   = o_wbs_q;
	assign out_wbp   = o_wbp_q;
	assign out_last  = o_last_q;

endmodule

### dv/lfu_dir_tb_pkg.sv
`timescale 1ns / 100ps
// lfu_dir_tb_pkg: result beat type and the directory shadow that predicts and checks beats
// for the lfu page cache directory testbench. Depends on lfu_pkg.
package lfu_dir_tb_pkg;
	import lfu_pkg::*;

	localparam int PRINT_CAP = 40;

	typedef enum logic {
		FUNC_ACCESS = 1'b0,
		FUNC_FLUSH  = 1'b1
	} dir_func_e;

	typedef struct packed {
		logic [IDX_W-1:0]  slot;
		logic              hit;
		logic              fill_needed;
		logic              wb_valid;
		logic [IDX_W-1:0]  wb_slot;
		logic [PAGE_W-1:0] wb_page;
		logic              last;
	} dir_beat_t;

	class directory_shadow;
		logic                  live [SLOTS];
		logic                  dirty [SLOTS];
		logic [PAGE_W-1:0]     page_of [SLOTS];
		logic [COUNT_BITS-1:0] uses [SLOTS];
		logic [NSLOT_W-1:0]    active_reg;
		dir_beat_t             due_beats [$];
		int unsigned           mismatches;

		function new();
			foreach (live[i]) begin
				live[i]    = 1'b0;
				dirty[i]   = 1'b0;
				page_of[i] = '0;
				uses[i]    = '0;
			end
			active_reg = NSLOT_W'(16);
			mismatches = 0;
		endfunction

		function void set_active(logic [NSLOT_W-1:0] value);
			active_reg = value;
		endfunction

		function int pending();
			return due_beats.size();
		endfunction

		function int unsigned failures();
			return mismatches;
		endfunction

		// expected beats of one accepted request, state updated as the block does
		function void note_request(dir_func_e f, logic [PAGE_W-1:0] pg, logic wr);
			int        n;
			int        last_dirty;
			int        free_i;
			int        victim_i;
			int        target;
			dir_beat_t beat;
			n = (active_reg == 0) ? 1 : int'(active_reg);
			if (n > SLOTS) n = SLOTS;
			if (n > 16) n = 16;
			beat = '0;
			if (f == FUNC_FLUSH) begin
				last_dirty = -1;
				for (int i = 0; i < n; i++)
					if (live[i] && dirty[i]) last_dirty = i;
				if (last_dirty < 0) begin
					// nothing dirty: one all-zero beat
					beat.last = 1'b1;
					due_beats.push_back(beat);
					return;
				end
				for (int i = 0; i <= last_dirty; i++) begin
					if (live[i] && dirty[i]) begin
						beat.slot     = IDX_W'(i);
						beat.wb_valid = 1'b1;
						beat.wb_slot  = IDX_W'(i);
						beat.wb_page  = page_of[i];
						beat.last     = (i == last_dirty);
						due_beats.push_back(beat);
						live[i]  = 1'b0;
						dirty[i] = 1'b0;
					end
				end
				return;
			end
			free_i   = -1;
			victim_i = -1;
			for (int i = 0; i < n; i++) begin
				if (live[i] && page_of[i] == pg) begin
					if (uses[i] != '1) uses[i]++;
					if (wr) dirty[i] = 1'b1;
					beat.slot = IDX_W'(i);
					beat.hit  = 1'b1;
					beat.last = 1'b1;
					due_beats.push_back(beat);
					return;
				end
				if (!live[i]) begin
					if (free_i < 0) free_i = i;
				end else if (victim_i < 0 || uses[i] < uses[victim_i]) begin
					victim_i = i;
				end
			end
			if (free_i >= 0) begin
				target = free_i;
			end else begin
				// evicted victim goes back to store, clean or not
				target        = victim_i;
				beat.wb_valid = 1'b1;
				beat.wb_slot  = IDX_W'(victim_i);
				beat.wb_page  = page_of[victim_i];
			end
			live[target]     = 1'b1;
			dirty[target]    = wr;
			page_of[target]  = pg;
			uses[target]     = COUNT_BITS'(1);
			beat.slot        = IDX_W'(target);
			beat.fill_needed = !wr;
			beat.last        = 1'b1;
			due_beats.push_back(beat);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [PAGE_W-1:0] got, logic [PAGE_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_beat(dir_beat_t got);
			dir_beat_t want;
			if (due_beats.size() == 0) begin
				report_mismatch($sformatf("beat for slot %0d with nothing expected", got.slot));
				return;
			end
			want = due_beats.pop_front();
			compare_field("slot", PAGE_W'(got.slot), PAGE_W'(want.slot));
			compare_field("hit", PAGE_W'(got.hit), PAGE_W'(want.hit));
			compare_field("fill_needed", PAGE_W'(got.fill_needed), PAGE_W'(want.fill_needed));
			compare_field("writeback_valid", PAGE_W'(got.wb_valid), PAGE_W'(want.wb_valid));
			compare_field("writeback_slot", PAGE_W'(got.wb_slot), PAGE_W'(want.wb_slot));
			compare_field("writeback_page", got.wb_page, want.wb_page);
			compare_field("last", PAGE_W'(got.last), PAGE_W'(want.last));
		endtask
	endclass

endpackage

### dv/tb.sv
`timescale 1ns / 100ps
// tb: top of the lfu page cache directory testbench; drives requests and active_slots,
// checks every result beat. Depends on lfu_pkg, the channel interfaces, lfu_dir_tb_pkg.
module tb;
	import lfu_pkg::*;
	import lfu_dir_tb_pkg::*;

	// under two hundred requests; even long flushes under long stalls stay far below this
	localparam int RUN_LIMIT_NS    = 5_000_000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_LIMIT     = 20_000;
	localparam int TAIL_CYCLES     = 40;
	localparam int POOL_SIZE       = 20;
	localparam int PHASE_ITEMS     = 18;

	logic clk;
	logic arst_n;

	lfu_cfg_if cfg ();
	lfu_req_if req ();
	lfu_res_if res ();

	lfu_page_cache_directory dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.res    (res)
	);

	directory_shadow   shadow = new();
	int unsigned       hold_off_req = 0;  // bumped by the sender to park the result side
	logic [PAGE_W-1:0] page_pool [POOL_SIZE];
	int unsigned       pool_span = POOL_SIZE;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#(RUN_LIMIT_NS);
		$display("tb NOT OK");
		$finish;
	end

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 50) return 0;
		if (roll < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// pages from a small pool so hits and evictions are common, some fully random
	function automatic logic [PAGE_W-1:0] pick_page();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 85) return page_pool[$urandom_range(pool_span - 1)];
		return $urandom;
	endfunction

	// offer one request beat and hold it until accepted; valid stays high when gap is 0
	// so a following call can present the next beat in the same step
	task automatic offer_request(dir_func_e f, logic [PAGE_W-1:0] pg, logic wr,
			int unsigned gap);
		req.valid       <= 1'b1;
		req.func        <= f;
		req.page_number <= pg;
		req.is_write    <= wr;
		do @(posedge clk); while (req.ready !== 1'b1);
		shadow.note_request(f, pg, wr);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait for every predicted beat to come back
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
	endtask

	// active_slots is only written with the block idle
	task automatic write_active(logic [NSLOT_W-1:0] value);
		wait_drained();
		cfg.valid        <= 1'b1;
		cfg.active_slots <= value;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		shadow.set_active(value);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_request();
		if ($urandom_range(99) < 10)
			offer_request(FUNC_FLUSH, $urandom, 1'($urandom_range(1)), pick_gap());
		else
			offer_request(FUNC_ACCESS, pick_page(), ($urandom_range(99) < 35), pick_gap());
	endtask

	// result side: check each accepted beat, then stall for a random gap or a long hold-off
	initial begin
		int unsigned stall_left;
		int unsigned hold_off_seen;
		dir_beat_t   got;
		stall_left    = 0;
		hold_off_seen = 0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				got.slot        = res.slot;
				got.hit         = res.hit;
				got.fill_needed = res.fill_needed;
				got.wb_valid    = res.writeback_valid;
				got.wb_slot     = res.writeback_slot;
				got.wb_page     = res.writeback_page;
				got.last        = res.last;
				shadow.check_beat(got);
				stall_left = pick_gap();
			end
			if (hold_off_req != hold_off_seen) begin
				hold_off_seen = hold_off_req;
				stall_left    = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// request side: directed cases, then random phases per setting
	initial begin
		logic [NSLOT_W-1:0] phase_act [6];
		logic [NSLOT_W-1:0] act;
		int                 n_eff;
		int                 settle;
		phase_act = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd17};

		arst_n           <= 1'b0;
		req.valid        <= 1'b0;
		req.func         <= FUNC_ACCESS;
		req.page_number  <= '0;
		req.is_write     <= 1'b0;
		cfg.valid        <= 1'b0;
		cfg.active_slots <= NSLOT_W'(16);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cold read miss, write miss at the top page, read hit, write hit turns dirty
		offer_request(FUNC_ACCESS, 32'h0000_0000, 1'b0, 0);
		offer_request(FUNC_ACCESS, 32'hFFFF_FFFF, 1'b1, 1);
		offer_request(FUNC_ACCESS, 32'h0000_0000, 1'b0, 0);
		offer_request(FUNC_ACCESS, 32'h0000_0000, 1'b1, 2);
		// flush with two dirty slots, then a flush with nothing left dirty
		offer_request(FUNC_FLUSH, 32'h0000_0000, 1'b0, 0);
		offer_request(FUNC_FLUSH, 32'hFFFF_FFFF, 1'b1, 0);

		// two slots: fill, tie on count goes to the lowest slot, then count decides
		write_active(5'd2);
		offer_request(FUNC_ACCESS, 32'h0000_0001, 1'b0, 0);
		offer_request(FUNC_ACCESS, 32'h8000_0000, 1'b0, 0);
		offer_request(FUNC_ACCESS, 32'h7FFF_FFFF, 1'b1, 0);
		offer_request(FUNC_ACCESS, 32'h7FFF_FFFF, 1'b0, 3);
		offer_request(FUNC_ACCESS, 32'hFFFF_FFFE, 1'b0, 0);
		offer_request(FUNC_FLUSH, 32'h0000_0000, 1'b0, 0);

		// zero acts as one slot; a clean victim is still written back
		write_active(5'd0);
		offer_request(FUNC_ACCESS, 32'h0F0F_0F0F, 1'b0, 0);
		offer_request(FUNC_ACCESS, 32'hF0F0_F0F0, 1'b1, 0);

		// out-of-range setting clamps to all slots; the entry left in slot 1 shows again
		write_active(5'd31);
		offer_request(FUNC_ACCESS, 32'hFFFF_FFFE, 1'b0, 0);
		offer_request(FUNC_FLUSH, 32'h0000_0000, 1'b0, 1);

		foreach (page_pool[i]) page_pool[i] = $urandom;

		for (int p = 0; p < 8; p++) begin
			act = (p < 6) ? phase_act[p] : NSLOT_W'($urandom_range(31));
			write_active(act);
			n_eff     = (act == 0) ? 1 : ((act > 16) ? 16 : int'(act));
			pool_span = n_eff + 3;
			// keep most of the pool so entries hidden by a smaller setting come back
			foreach (page_pool[i])
				if ($urandom_range(3) == 0) page_pool[i] = $urandom;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 2 && k == 4) begin
					// park the result side and keep pushing so the input backs up
					hold_off_req++;
					repeat (14)
						offer_request(FUNC_ACCESS, pick_page(), 1'($urandom_range(1)), 0);
				end
				if (p == 4 && k == 11) wait_drained();
				random_request();
			end
		end

		req.valid <= 1'b0;
		settle = 0;
		while (shadow.pending() != 0 && settle < DRAIN_LIMIT) begin
			@(posedge clk);
			settle++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.pending() != 0)
			shadow.report_mismatch($sformatf("%0d beats never arrived", shadow.pending()));
		if (shadow.failures() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
